[hw/rtl/ols_pkg.sv]
// Shared types and constants for the option line splitter.
// Holds the request structs, status codes and length limits; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ols_pkg;

  // Length limits of one line
  localparam int NAME_MAX_LEN  = 63;
  localparam int VALUE_MAX_LEN = 255;
  localparam int LINE_MAX_LEN  = 1023;

  // Internal widths derived from the limits
  localparam int POS_W  = $clog2(LINE_MAX_LEN + 2);   // 0 .. LINE_MAX_LEN+1
  localparam int VPOS_W = $clog2(LINE_MAX_LEN);       // 0 .. LINE_MAX_LEN-1
  localparam int NCNT_W = $clog2(NAME_MAX_LEN + 2);   // 0 .. NAME_MAX_LEN+1

  // Fixed result field widths
  localparam int NAME_LEN_W  = 6;
  localparam int VSTART_W    = 10;
  localparam int VLEN_W      = 8;
  localparam int STATUS_W    = 3;

  // Special bytes
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_HASH  = 8'h23;
  localparam logic [7:0] CHAR_UNDER = 8'h5F;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_EMPTY       = 3'd1,
    ST_LINE_LONG   = 3'd2,
    ST_BAD_NAME    = 3'd3,
    ST_NO_COLON    = 3'd4,
    ST_NAME_LONG   = 3'd5,
    ST_EMPTY_VALUE = 3'd6,
    ST_VALUE_LONG  = 3'd7
  } status_e;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       byte_present;
    logic       line_end;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [NAME_LEN_W-1:0] name_length;
    logic [VSTART_W-1:0]   value_start;
    logic [VLEN_W-1:0]     value_length;
  } out_item_t;

  // Byte classification flags
  typedef struct packed {
    logic ws;
    logic name;
    logic colon;
    logic hash;
  } byte_class_t;

endpackage

`default_nettype wire

[hw/rtl/ols_byte_class.sv]
// Byte classifier for the option line splitter.
// Flags whitespace, name bytes, colon and hash; uses ols_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ols_byte_class (
  input  logic [7:0]           char_byte_i,
  output ols_pkg::byte_class_t class_o
);

  always_comb begin
    class_o.ws    = ((char_byte_i >= 8'd9) && (char_byte_i <= 8'd13)) ||
                    (char_byte_i == 8'd32);
    class_o.name  = ((char_byte_i >= 8'h61) && (char_byte_i <= 8'h7A)) ||
                    ((char_byte_i >= 8'h41) && (char_byte_i <= 8'h5A)) ||
                    ((char_byte_i >= 8'h30) && (char_byte_i <= 8'h39)) ||
                    (char_byte_i == ols_pkg::CHAR_UNDER);
    class_o.colon = (char_byte_i == ols_pkg::CHAR_COLON);
    class_o.hash  = (char_byte_i == ols_pkg::CHAR_HASH);
  end

endmodule

`default_nettype wire

[hw/rtl/ols_line_state.sv]
// Per-line state of the option line splitter: byte counters, colon and value
// tracking, and the status decision at line end. Uses ols_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ols_line_state (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  ols_pkg::in_item_t    item_i,
  input  ols_pkg::byte_class_t class_i,
  output ols_pkg::out_item_t   result_o
);

  localparam int PosW  = ols_pkg::POS_W;
  localparam int VposW = ols_pkg::VPOS_W;
  localparam int NcntW = ols_pkg::NCNT_W;
  localparam int NlenW = ols_pkg::NAME_LEN_W;
  localparam int VsW   = ols_pkg::VSTART_W;
  localparam int VlW   = ols_pkg::VLEN_W;

  localparam logic [PosW-1:0]  LineLim  = PosW'(ols_pkg::LINE_MAX_LEN);
  localparam logic [31:0]      NameMax  = 32'(ols_pkg::NAME_MAX_LEN);
  localparam logic [31:0]      ValueMax = 32'(ols_pkg::VALUE_MAX_LEN);
  localparam logic [NcntW-1:0] NameSat  = NcntW'(ols_pkg::NAME_MAX_LEN + 1);

  logic [PosW-1:0]  pos_q, pos_d;
  logic             skipped_q, skipped_d;
  logic             colon_q, colon_d;
  logic             bad_q, bad_d;
  logic [NcntW-1:0] ncnt_q, ncnt_d;
  logic [VposW-1:0] first_q, first_d;
  logic [VposW-1:0] last_q, last_d;
  logic             vseen_q, vseen_d;

  logic [PosW-1:0]     vlen;
  ols_pkg::status_e    status;

  // Advance the line state by one byte
  always_comb begin
    pos_d     = pos_q;
    skipped_d = skipped_q;
    colon_d   = colon_q;
    bad_d     = bad_q;
    ncnt_d    = ncnt_q;
    first_d   = first_q;
    last_d    = last_q;
    vseen_d   = vseen_q;
    if (item_i.byte_present) begin
      if (pos_q >= LineLim) begin
        if (pos_q == LineLim) begin
          pos_d = pos_q + PosW'(1);
        end
      end else begin
        if ((pos_q == '0) && (class_i.ws || class_i.hash)) begin
          skipped_d = 1'b1;
        end
        if (!colon_q) begin
          if (class_i.colon) begin
            colon_d = 1'b1;
            ncnt_d  = (32'(pos_q) > NameMax) ? NameSat : NcntW'(pos_q);
          end else if ((32'(pos_q) <= NameMax) && !class_i.name) begin
            bad_d = 1'b1;
          end
        end else if (!class_i.ws) begin
          if (!vseen_q) begin
            vseen_d = 1'b1;
            first_d = VposW'(pos_q);
          end
          last_d = VposW'(pos_q);
        end
        pos_d = pos_q + PosW'(1);
      end
    end
  end

  // Decide the status from the state including this byte
  always_comb begin
    vlen = PosW'(last_d) - PosW'(first_d) + PosW'(1);
    if ((pos_d == '0) || skipped_d) begin
      status = ols_pkg::ST_EMPTY;
    end else if (pos_d > LineLim) begin
      status = ols_pkg::ST_LINE_LONG;
    end else if (bad_d) begin
      status = ols_pkg::ST_BAD_NAME;
    end else if (!colon_d && (32'(pos_d) <= NameMax + 32'd1)) begin
      status = ols_pkg::ST_NO_COLON;
    end else if (!colon_d || (32'(ncnt_d) > NameMax)) begin
      status = ols_pkg::ST_NAME_LONG;
    end else if (!vseen_d) begin
      status = ols_pkg::ST_EMPTY_VALUE;
    end else if (32'(vlen) > ValueMax) begin
      status = ols_pkg::ST_VALUE_LONG;
    end else begin
      status = ols_pkg::ST_OK;
    end

    result_o.status = status;
    if (status == ols_pkg::ST_OK) begin
      result_o.name_length  = NlenW'(ncnt_d);
      result_o.value_start  = VsW'(first_d);
      result_o.value_length = VlW'(vlen);
    end else begin
      result_o.name_length  = '0;
      result_o.value_start  = '0;
      result_o.value_length = '0;
    end
  end

  // Hold between steps; clear after every line end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      skipped_q <= 1'b0;
      colon_q   <= 1'b0;
      bad_q     <= 1'b0;
      ncnt_q    <= '0;
      first_q   <= '0;
      last_q    <= '0;
      vseen_q   <= 1'b0;
    end else if (step_i) begin
      if (item_i.line_end) begin
        pos_q     <= '0;
        skipped_q <= 1'b0;
        colon_q   <= 1'b0;
        bad_q     <= 1'b0;
        ncnt_q    <= '0;
        first_q   <= '0;
        last_q    <= '0;
        vseen_q   <= 1'b0;
      end else begin
        pos_q     <= pos_d;
        skipped_q <= skipped_d;
        colon_q   <= colon_d;
        bad_q     <= bad_d;
        ncnt_q    <= ncnt_d;
        first_q   <= first_d;
        last_q    <= last_d;
        vseen_q   <= vseen_d;
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/option_line_splitter.sv]
// Top level of the option line splitter: input register, line state and
// result register. Depends on ols_pkg, ols_byte_class and ols_line_state.
//
//   channel | direction | payload               | handshake
//   --------+-----------+-----------------------+-----------------------------
//   in      | to block  | ols_pkg::in_item_t    | in_valid_i / in_stall_o
//   out     | from block| ols_pkg::out_item_t   | out_valid_o / out_stall_i
//
// One request per cycle unless the input is stalled; each is folded into the line state as it
// leaves the input register, and a line end loads the result register as it does so.
// An out stall holds the result and holds a line end in the input register;
// plain bytes keep flowing under a stalled result.
// Reset clears the valid flags and the line state, not the payload registers.
`timescale 1ns / 1ps
`default_nettype none

module option_line_splitter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ols_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ols_pkg::out_item_t out_item_o
);

  logic                 in_valid_q;
  ols_pkg::in_item_t    in_item_q;
  logic                 out_valid_q;
  ols_pkg::out_item_t   out_item_q;

  logic                 out_free;
  logic                 advance;
  logic                 load_result;
  ols_pkg::byte_class_t byte_class;
  ols_pkg::out_item_t   result;

  // The result slot is free when empty or being drained this cycle
  assign out_free    = !out_valid_q || !out_stall_i;
  // Advance the input request; a line end needs room for its result
  assign advance     = in_valid_q && (!in_item_q.line_end || out_free);
  assign load_result = advance && in_item_q.line_end;
  assign in_stall_o  = in_valid_q && !advance;

  ols_byte_class u_byte_class (
    .char_byte_i (in_item_q.char_byte),
    .class_o     (byte_class)
  );

  ols_line_state u_line_state (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (in_item_q),
    .class_i  (byte_class),
    .result_o (result)
  );

  // Input register: take a new request whenever the held one moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_item_q <= in_item_i;
    end
  end

  // Result register: hold under stall, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_result) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_result) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

[hw/rtl/ols_checker.sv]
// Port-level checker for option_line_splitter, bound to the top level.
// Depends on ols_pkg and the option_line_splitter port list.
`timescale 1ns / 1ps
`default_nettype none

module ols_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input ols_pkg::in_item_t  in_item_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input ols_pkg::out_item_t out_item_o
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // Never stall the input while the result slot can take a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || !out_stall_i) |-> !in_stall_o)
    else $error("input stalled with free result slot");

  // Failing lines carry no lengths
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status != ols_pkg::ST_OK) |->
      (out_item_o.name_length == '0) && (out_item_o.value_start == '0) &&
      (out_item_o.value_length == '0))
    else $error("non-ok result with nonzero fields");

  // A good value starts after the colon
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status == ols_pkg::ST_OK) |->
      (out_item_o.value_start > 10'(out_item_o.name_length)))
    else $error("value starts before the colon");

endmodule

bind option_line_splitter ols_checker u_ols_checker (.*);

`default_nettype wire
